// ===== rtl/enwa_pkg.sv =====
// ----------------------------------------------------------------------------
// enwa_pkg
// Shared constants for the epsilon NFA word acceptor: default automaton size,
// field widths, word kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
package enwa_pkg;

  // Default automaton size.
  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_SYMBOLS_DEF = 8;

  // Widths of the word and result fields.
  localparam int KIND_W = 2;
  localparam int SRC_W  = 4;
  localparam int RSYM_W = 4;
  localparam int MASK_W = 16;
  localparam int SYM_W  = 3;

  // Word kinds. The fourth code is ignored by the block.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL   = 1'b1;

endpackage

// ===== rtl/enwa_ram.sv =====
// ----------------------------------------------------------------------------
// enwa_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module enwa_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 144,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/epsilon_nfa_word_acceptor_unit.sv =====
// ----------------------------------------------------------------------------
// epsilon_nfa_word_acceptor_unit
// Word recognizer for a nondeterministic automaton with epsilon moves,
// simulated as a set of active states stepped through a transition table.
//
// After reset the block clears the whole transition table and holds in_ready
// low meanwhile; configuration writes are taken at any time. The table has
// one read port, and every table row that the active set needs is read there
// one per cycle. A row comes back in the cycle after its read, so a state
// that is only reached through a row still in flight waits until that row
// has come back before its own row is read. A start word closes the initial
// set under epsilon moves. A symbol word first reads one row for each state
// active before the word and then closes the moved set in the same way as a
// start word. A full result register holds the block before it gives its
// result. Every word gives exactly one result word.
// ----------------------------------------------------------------------------
module epsilon_nfa_word_acceptor_unit #(
  parameter int NUM_STATES  = enwa_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = enwa_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           cfg_we,
  input  logic [enwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [enwa_pkg::MASK_W-1:0]    cfg_wdata,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [enwa_pkg::KIND_W-1:0]    in_kind,
  input  logic [enwa_pkg::SRC_W-1:0]     in_source_state,
  input  logic [enwa_pkg::RSYM_W-1:0]    in_row_symbol,
  input  logic [enwa_pkg::MASK_W-1:0]    in_next_state_mask,
  input  logic [enwa_pkg::SYM_W-1:0]     in_symbol,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_accepted,
  output logic                           out_alive,
  output logic [enwa_pkg::MASK_W-1:0]    out_active_states
);

  localparam int ROWS    = NUM_SYMBOLS + 1;
  localparam int EPS_ROW = NUM_SYMBOLS;
  localparam int DEPTH   = NUM_STATES * ROWS;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(NUM_STATES);
  localparam int N       = NUM_STATES;

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOVE  = 5'b00100,
    ST_CLOSE = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [AW-1:0]                  clr_cnt_r, clr_cnt_nxt;
  logic [N-1:0]                   init_r, init_nxt;
  logic [N-1:0]                   fin_r, fin_nxt;
  logic [N-1:0]                   cur_set_r, cur_set_nxt;
  logic [N-1:0]                   set_r, set_nxt;
  logic [N-1:0]                   acc_r, acc_nxt;
  logic [N-1:0]                   done_r, done_nxt;
  logic [enwa_pkg::SYM_W-1:0]     sym_r, sym_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_acc_r, out_acc_nxt;
  logic                           out_alive_r, out_alive_nxt;
  logic [enwa_pkg::MASK_W-1:0]    out_set_r, out_set_nxt;

  logic [N-1:0]                   pend;
  logic [N-1:0]                   low;
  logic [SW-1:0]                  idx;
  logic [AW-1:0]                  row_sel;
  logic                           issue;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [N-1:0]                   ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [N-1:0]                   ram_rdata;

  // Transition table, one next-state set per state and symbol row.
  enwa_ram #(
    .WIDTH  (N),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Pick the lowest state that still needs its row read, and form the address.
  always_comb begin
    pend    = ((state_r == ST_MOVE) ? set_r : acc_r) & ~done_r;
    low     = pend & (~pend + N'(1));
    idx     = '0;
    for (int i = 0; i < N; i++) begin
      if (low[i]) begin
        idx = idx | SW'(i);
      end
    end
    row_sel   = (state_r == ST_MOVE) ? AW'(sym_r) : AW'(EPS_ROW);
    ram_raddr = AW'(int'(idx) * ROWS) + row_sel;
    issue     = ((state_r == ST_MOVE) || (state_r == ST_CLOSE)) && (pend != '0);
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    init_nxt      = init_r;
    fin_nxt       = fin_r;
    cur_set_nxt   = cur_set_r;
    set_nxt       = set_r;
    acc_nxt       = acc_r;
    done_nxt      = done_r;
    sym_nxt       = sym_r;
    rd_vld_nxt    = issue;
    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_alive_nxt = out_alive_r;
    out_set_nxt   = out_set_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = '0;

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_index)
        enwa_pkg::CFG_INITIAL: init_nxt = N'(cfg_wdata);
        enwa_pkg::CFG_FINAL:   fin_nxt  = N'(cfg_wdata);
        default: ;
      endcase
    end

    // A taken result frees the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        ram_we = 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            enwa_pkg::KIND_LOAD: begin
              if ((int'(in_source_state) < NUM_STATES) &&
                  (int'(in_row_symbol) <= EPS_ROW)) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(int'(in_source_state) * ROWS + int'(in_row_symbol));
                ram_wdata = N'(in_next_state_mask);
              end
              state_nxt = ST_FIN;
            end
            enwa_pkg::KIND_START: begin
              acc_nxt   = init_r;
              done_nxt  = '0;
              state_nxt = ST_CLOSE;
            end
            enwa_pkg::KIND_STEP: begin
              acc_nxt  = '0;
              done_nxt = '0;
              sym_nxt  = in_symbol;
              set_nxt  = cur_set_r;
              // A symbol outside the alphabet leaves no state alive.
              if (int'(in_symbol) >= NUM_SYMBOLS) begin
                state_nxt = ST_CLOSE;
              end else begin
                state_nxt = ST_MOVE;
              end
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_MOVE: begin
        if (issue) begin
          done_nxt = done_r | low;
        end
        if (rd_vld_r) begin
          acc_nxt = acc_r | ram_rdata;
        end
        if ((pend == '0) && !rd_vld_r) begin
          done_nxt  = '0;
          state_nxt = ST_CLOSE;
        end
      end

      ST_CLOSE: begin
        // Returned epsilon rows grow the set, which in turn adds pending states.
        if (issue) begin
          done_nxt = done_r | low;
        end
        if (rd_vld_r) begin
          acc_nxt = acc_r | ram_rdata;
        end
        if ((pend == '0) && !rd_vld_r) begin
          cur_set_nxt = acc_r;
          state_nxt   = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = |(cur_set_r & fin_r);
          out_alive_nxt = |cur_set_r;
          out_set_nxt   = enwa_pkg::MASK_W'(cur_set_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      init_r      <= N'(1);
      fin_r       <= '0;
      cur_set_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      init_r      <= init_nxt;
      fin_r       <= fin_nxt;
      cur_set_r   <= cur_set_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result data registers.
  always_ff @(posedge clk) begin
    set_r       <= set_nxt;
    acc_r       <= acc_nxt;
    done_r      <= done_nxt;
    sym_r       <= sym_nxt;
    out_acc_r   <= out_acc_nxt;
    out_alive_r <= out_alive_nxt;
    out_set_r   <= out_set_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_alive         = out_alive_r;
  assign out_active_states = out_set_r;

endmodule
